### sv/lsc_pkg.sv
`default_nettype none

package lsc_pkg;

  localparam int unsigned CFG_BITS       = 12;
  localparam int unsigned CFG_IDX_BITS   = 2;
  localparam int unsigned COORD_BITS_DEF = 13;

  localparam logic [CFG_IDX_BITS-1:0] CFG_SCREEN_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SCREEN_HEIGHT = 2'd1;

  localparam logic [CFG_BITS-1:0] SCREEN_WIDTH_RST  = 12'd640;
  localparam logic [CFG_BITS-1:0] SCREEN_HEIGHT_RST = 12'd480;

  localparam int unsigned MAX_STEPS      = 8;
  localparam int unsigned STEP_CNT_BITS  = $clog2(MAX_STEPS + 1);

  // outcode bit positions
  localparam int unsigned OC_BOTTOM = 0;
  localparam int unsigned OC_LEFT   = 1;
  localparam int unsigned OC_TOP    = 2;
  localparam int unsigned OC_RIGHT  = 3;

  typedef logic [3:0] outcode_t;

  typedef enum logic [2:0] {
    OP_LOAD,
    OP_TEST,
    OP_MUL,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_DIV_FIX,
    OP_UPDATE,
    OP_EMIT
  } op_t;

  typedef enum logic [2:0] {
    CND_NEVER,
    CND_ALWAYS,
    CND_NO_INPUT,
    CND_SETTLED,
    CND_DIV_MORE,
    CND_OUT_FULL
  } cond_t;

  localparam int unsigned PC_BITS = 3;
  typedef logic [PC_BITS-1:0] pc_t;

  localparam pc_t PC_IDLE     = 3'd0;
  localparam pc_t PC_TEST     = 3'd1;
  localparam pc_t PC_MUL      = 3'd2;
  localparam pc_t PC_DIV_INIT = 3'd3;
  localparam pc_t PC_DIV_STEP = 3'd4;
  localparam pc_t PC_DIV_FIX  = 3'd5;
  localparam pc_t PC_UPDATE   = 3'd6;
  localparam pc_t PC_EMIT     = 3'd7;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    pc_t   target;
  } uword_t;

  // jump to target when the condition holds, else advance; emit wraps to idle
  function automatic uword_t ucode_rom(pc_t pc);
    uword_t w;
    unique case (pc)
      PC_IDLE:     w = '{op: OP_LOAD,     cond: CND_NO_INPUT, target: PC_IDLE};
      PC_TEST:     w = '{op: OP_TEST,     cond: CND_SETTLED,  target: PC_EMIT};
      PC_MUL:      w = '{op: OP_MUL,      cond: CND_NEVER,    target: PC_IDLE};
      PC_DIV_INIT: w = '{op: OP_DIV_INIT, cond: CND_NEVER,    target: PC_IDLE};
      PC_DIV_STEP: w = '{op: OP_DIV_STEP, cond: CND_DIV_MORE, target: PC_DIV_STEP};
      PC_DIV_FIX:  w = '{op: OP_DIV_FIX,  cond: CND_NEVER,    target: PC_IDLE};
      PC_UPDATE:   w = '{op: OP_UPDATE,   cond: CND_ALWAYS,   target: PC_TEST};
      PC_EMIT:     w = '{op: OP_EMIT,     cond: CND_OUT_FULL, target: PC_EMIT};
      default:     w = '{op: OP_LOAD,     cond: CND_NO_INPUT, target: PC_IDLE};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

### sv/line_segment_clipper.sv
// The time from input word to result word grows with k, the number of edge crossings (0 to 8).
// Each crossing runs one multiply and a COORD_BITS+1 step restoring divide on the shared unit.
// One segment at a time; the next input word is taken the cycle after the result is registered.
// Reset is synchronous, active low: sequencer to idle, output empty, screen 640 x 480.
`default_nettype none

module line_segment_clipper
  import lsc_pkg::*;
#(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic signed [COORD_BITS-1:0] in_start_x,
  input  wire logic signed [COORD_BITS-1:0] in_start_y,
  input  wire logic signed [COORD_BITS-1:0] in_end_x,
  input  wire logic signed [COORD_BITS-1:0] in_end_y,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic                              out_accepted,
  output logic signed [COORD_BITS-1:0]      out_clip_start_x,
  output logic signed [COORD_BITS-1:0]      out_clip_start_y,
  output logic signed [COORD_BITS-1:0]      out_clip_end_x,
  output logic signed [COORD_BITS-1:0]      out_clip_end_y,
  input  wire logic                         cfg_wr_en,
  input  wire logic [CFG_IDX_BITS-1:0]      cfg_index,
  input  wire logic [CFG_BITS-1:0]          cfg_data
);

  localparam int unsigned EW = ((COORD_BITS > CFG_BITS + 1) ? COORD_BITS : CFG_BITS + 1) + 1;
  localparam int unsigned D  = COORD_BITS + 1;
  localparam int unsigned P  = 2 * D;
  localparam int unsigned DCNT_BITS = $clog2(D + 1);

  function automatic outcode_t outcode(logic signed [EW-1:0] x, logic signed [EW-1:0] y,
                                       logic signed [EW-1:0] w, logic signed [EW-1:0] h);
    outcode_t c;
    c = '0;
    if (y > h) begin
      c[OC_TOP] = 1'b1;
    end else if (y < 0) begin
      c[OC_BOTTOM] = 1'b1;
    end
    if (x > w) begin
      c[OC_RIGHT] = 1'b1;
    end else if (x < 0) begin
      c[OC_LEFT] = 1'b1;
    end
    return c;
  endfunction

  // control
  pc_t    pc_r, pc_nxt;
  uword_t uw;
  logic   cond_hit;
  logic   out_full;
  logic   out_valid_r, out_valid_nxt;
  logic   [CFG_BITS-1:0] screen_width_r, screen_height_r;

  // datapath
  logic signed [COORD_BITS-1:0] x0_r, y0_r, x1_r, y1_r;
  logic signed [COORD_BITS-1:0] sx_r, sy_r, ex_r, ey_r;
  logic [STEP_CNT_BITS-1:0]     clip_cnt_r;
  logic                         accept_r, sel_end_r, axis_y_r;
  logic signed [EW-1:0]         edge_r;
  logic signed [COORD_BITS-1:0] a0_r;
  logic signed [D-1:0]          fa_r, fe_r, den_r;
  logic signed [P-1:0]          prod_r;
  logic                         neg_r;
  logic [D-1:0]                 rem_r, qsh_r, dvs_r;
  logic [DCNT_BITS-1:0]         dcnt_r;
  logic signed [D-1:0]          quot_r;

  logic                         out_accepted_r;
  logic signed [COORD_BITS-1:0] out_sx_r, out_sy_r, out_ex_r, out_ey_r;

  // edge selection
  logic signed [EW-1:0] xe0, ye0, xe1, ye1, we, he;
  outcode_t             c0, c1, csel;
  logic                 t_axis_y, t_sel_end, t_den_zero, t_settled, t_accept;
  logic signed [EW-1:0] t_edge, t_fa, t_fe, t_den;
  logic signed [COORD_BITS-1:0] t_a0;

  // arithmetic
  logic signed [P-1:0] mul_a, mul_b;
  logic [P-1:0]        num_mag;
  logic [D:0]          rem_sh, rem_sub;
  logic                rem_ge;
  logic signed [D-1:0] new_a;
  logic signed [COORD_BITS-1:0] new_b;

  assign uw       = ucode_rom(pc_r);
  assign out_full = out_valid_r && out_stall;
  assign in_stall = (pc_r != PC_IDLE);

  assign xe0 = EW'(x0_r);
  assign ye0 = EW'(y0_r);
  assign xe1 = EW'(x1_r);
  assign ye1 = EW'(y1_r);
  assign we  = $signed(EW'(screen_width_r));
  assign he  = $signed(EW'(screen_height_r));

  always_comb begin
    c0        = outcode(xe0, ye0, we, he);
    c1        = outcode(xe1, ye1, we, he);
    t_sel_end = (c0 == '0);
    csel      = t_sel_end ? c1 : c0;
    if (csel[OC_TOP]) begin
      t_axis_y = 1'b1;
      t_edge   = he;
    end else if (csel[OC_BOTTOM]) begin
      t_axis_y = 1'b1;
      t_edge   = '0;
    end else if (csel[OC_RIGHT]) begin
      t_axis_y = 1'b0;
      t_edge   = we;
    end else begin
      t_axis_y = 1'b0;
      t_edge   = '0;
    end
    if (t_axis_y) begin
      t_a0  = x0_r;
      t_fa  = xe1 - xe0;
      t_fe  = t_edge - ye0;
      t_den = ye1 - ye0;
    end else begin
      t_a0  = y0_r;
      t_fa  = ye1 - ye0;
      t_fe  = t_edge - xe0;
      t_den = xe1 - xe0;
    end
    t_den_zero = (t_den == '0);
    t_accept   = ((c0 | c1) == '0);
    t_settled  = t_accept || ((c0 & c1) != '0) || t_den_zero ||
                 (clip_cnt_r == STEP_CNT_BITS'(MAX_STEPS));
  end

  assign mul_a   = P'(fa_r);
  assign mul_b   = P'(fe_r);
  assign num_mag = prod_r[P-1] ? P'(-prod_r) : P'(prod_r);
  assign rem_sh  = {rem_r, qsh_r[D-1]};
  assign rem_ge  = (rem_sh >= {1'b0, dvs_r});
  assign rem_sub = rem_sh - {1'b0, dvs_r};
  assign new_a   = D'(a0_r) + quot_r;
  assign new_b   = COORD_BITS'(edge_r);

  always_comb begin
    case (uw.cond)
      CND_NEVER:    cond_hit = 1'b0;
      CND_ALWAYS:   cond_hit = 1'b1;
      CND_NO_INPUT: cond_hit = !in_valid;
      CND_SETTLED:  cond_hit = t_settled;
      CND_DIV_MORE: cond_hit = (dcnt_r != DCNT_BITS'(1));
      CND_OUT_FULL: cond_hit = out_full;
      default:      cond_hit = 1'b0;
    endcase
    pc_nxt = cond_hit ? uw.target : pc_r + pc_t'(1);
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (uw.op == OP_EMIT && !out_full) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r            <= PC_IDLE;
      out_valid_r     <= 1'b0;
      screen_width_r  <= SCREEN_WIDTH_RST;
      screen_height_r <= SCREEN_HEIGHT_RST;
    end else begin
      pc_r        <= pc_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        unique case (cfg_index)
          CFG_SCREEN_WIDTH:  screen_width_r  <= cfg_data;
          CFG_SCREEN_HEIGHT: screen_height_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    case (uw.op)
      OP_LOAD: begin
        if (in_valid) begin
          x0_r       <= in_start_x;
          y0_r       <= in_start_y;
          x1_r       <= in_end_x;
          y1_r       <= in_end_y;
          sx_r       <= in_start_x;
          sy_r       <= in_start_y;
          ex_r       <= in_end_x;
          ey_r       <= in_end_y;
          clip_cnt_r <= '0;
        end
      end
      OP_TEST: begin
        accept_r  <= t_accept;
        sel_end_r <= t_sel_end;
        axis_y_r  <= t_axis_y;
        edge_r    <= t_edge;
        a0_r      <= t_a0;
        fa_r      <= t_fa[D-1:0];
        fe_r      <= t_fe[D-1:0];
        den_r     <= t_den[D-1:0];
      end
      OP_MUL: begin
        prod_r <= mul_a * mul_b;
      end
      OP_DIV_INIT: begin
        neg_r  <= prod_r[P-1] ^ den_r[D-1];
        rem_r  <= num_mag[P-1:D];
        qsh_r  <= num_mag[D-1:0];
        dvs_r  <= den_r[D-1] ? D'(-den_r) : D'(den_r);
        dcnt_r <= DCNT_BITS'(D);
      end
      OP_DIV_STEP: begin
        rem_r  <= rem_ge ? rem_sub[D-1:0] : rem_sh[D-1:0];
        qsh_r  <= {qsh_r[D-2:0], rem_ge};
        dcnt_r <= dcnt_r - DCNT_BITS'(1);
      end
      OP_DIV_FIX: begin
        quot_r <= neg_r ? -$signed(qsh_r) : $signed(qsh_r);
      end
      OP_UPDATE: begin
        clip_cnt_r <= clip_cnt_r + STEP_CNT_BITS'(1);
        if (sel_end_r) begin
          x1_r <= axis_y_r ? COORD_BITS'(new_a) : new_b;
          y1_r <= axis_y_r ? new_b : COORD_BITS'(new_a);
        end else begin
          x0_r <= axis_y_r ? COORD_BITS'(new_a) : new_b;
          y0_r <= axis_y_r ? new_b : COORD_BITS'(new_a);
        end
      end
      OP_EMIT: begin
        if (!out_full) begin
          out_accepted_r <= accept_r;
          out_sx_r       <= accept_r ? x0_r : sx_r;
          out_sy_r       <= accept_r ? y0_r : sy_r;
          out_ex_r       <= accept_r ? x1_r : ex_r;
          out_ey_r       <= accept_r ? y1_r : ey_r;
        end
      end
      default: ;
    endcase
  end

  assign out_valid        = out_valid_r;
  assign out_accepted     = out_accepted_r;
  assign out_clip_start_x = out_sx_r;
  assign out_clip_start_y = out_sy_r;
  assign out_clip_end_x   = out_ex_r;
  assign out_clip_end_y   = out_ey_r;

`ifndef SYNTH
  a_load_to_test: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (pc_r == PC_TEST))
    else $error("accepted word did not start the clip loop");

  a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
    (pc_r == PC_DIV_STEP) |-> (rem_r < dvs_r))
    else $error("divider remainder not below divisor");

  a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (pc_r != PC_IDLE) |-> (clip_cnt_r <= STEP_CNT_BITS'(MAX_STEPS)))
    else $error("clip step count beyond bound");

  a_accepted_on_screen: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_accepted_r) |->
      (out_sx_r >= 0 && EW'(out_sx_r) <= we && out_sy_r >= 0 && EW'(out_sy_r) <= he &&
       out_ex_r >= 0 && EW'(out_ex_r) <= we && out_ey_r >= 0 && EW'(out_ey_r) <= he))
    else $error("accepted segment endpoint off screen");
`endif

endmodule

`default_nettype wire
